[rtl/mgs_pkg.sv]
// ----------------------------------------------------------------------------
// mgs_pkg: shared types and constants of the meter grid snap block
// Table geometry, field widths, mode and status codes, sequencer states,
// divider request and the clamp used on every snapped result of a non-empty table.
// ----------------------------------------------------------------------------
package mgs_pkg;

   localparam int TABLE_DEPTH = 64;
   localparam int ADDR_W      = $clog2(TABLE_DEPTH);
   localparam int CNT_W       = $clog2(TABLE_DEPTH + 1);

   localparam int TICK_W  = 29;
   localparam int METER_W = 6;
   localparam int ENTRY_W = TICK_W + 2 * METER_W;

   localparam logic [TICK_W-1:0] SEG_END_DEFAULT = 29'h1FFF_FFFF;
   localparam logic [30:0]       OUT_MAX         = 31'h7FFF_FFFF;

   localparam int DVD_W  = 34;
   localparam int DSR_W  = 24;
   localparam int DCNT_W = $clog2(DVD_W + 1);

   typedef logic [1:0] mode_type;
   localparam mode_type MODE_CLEAR  = 2'd0;
   localparam mode_type MODE_APPEND = 2'd1;
   localparam mode_type MODE_SUBDIV = 2'd2;
   localparam mode_type MODE_BAR    = 2'd3;

   typedef logic [1:0] status_type;
   localparam status_type STS_OK    = 2'd0;
   localparam status_type STS_FULL  = 2'd1;
   localparam status_type STS_ORDER = 2'd2;

   localparam logic CSR_TPQ  = 1'b0;
   localparam logic CSR_SUBD = 1'b1;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_SCAN,
      ST_ISS_BEAT,
      ST_DIV_BEAT,
      ST_LEN,
      ST_ISS_A,
      ST_DIV_A,
      ST_MUL_A,
      ST_SUM_A,
      ST_CHK,
      ST_ISS_B,
      ST_DIV_B,
      ST_MUL_B,
      ST_ISS_C,
      ST_DIV_C,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic             start;
      logic [DVD_W-1:0] dividend;
      logic [DSR_W-1:0] divisor;
   } div_req_type;

   // clamp to the segment end where allowed, then saturate to 31 bits
   function automatic logic [30:0] snap_limit(input logic [34:0]       v,
                                              input logic [TICK_W-1:0] seg,
                                              input logic              cc);
      logic [34:0] c;
      c = (cc && (v >= 35'(seg))) ? 35'(seg) : v;
      if (c > 35'(OUT_MAX)) begin
         snap_limit = OUT_MAX;
      end else begin
         snap_limit = c[30:0];
      end
   endfunction

endpackage

[rtl/mgs_ram.sv]
// ----------------------------------------------------------------------------
// mgs_ram: generic single-port-write, single-port-read RAM
// One write and one registered read per cycle.
// ----------------------------------------------------------------------------
module mgs_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/mgs_div.sv]
// ----------------------------------------------------------------------------
// mgs_div: restoring unsigned divider
// One quotient bit per cycle; done is high for a single cycle, as the last bit lands.
// ----------------------------------------------------------------------------
module mgs_div (
   input  logic                      clock,
   input  logic                      reset,
   input  mgs_pkg::div_req_type      req,
   output logic                      done,
   output logic [mgs_pkg::DVD_W-1:0] quotient
);

   logic                       busy_ff;
   logic                       done_ff;
   logic [mgs_pkg::DCNT_W-1:0] cnt_ff;
   logic [mgs_pkg::DVD_W-1:0]  quo_ff;
   logic [mgs_pkg::DSR_W-1:0]  rem_ff;
   logic [mgs_pkg::DSR_W-1:0]  dsr_ff;
   logic [mgs_pkg::DSR_W:0]    shift;
   logic [mgs_pkg::DSR_W:0]    diff;
   logic                       ge;

   assign shift = {rem_ff, quo_ff[mgs_pkg::DVD_W-1]};
   assign ge    = shift >= {1'b0, dsr_ff};
   assign diff  = shift - {1'b0, dsr_ff};

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (req.start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= mgs_pkg::DCNT_W'(mgs_pkg::DVD_W);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - mgs_pkg::DCNT_W'(1);
            if (cnt_ff == mgs_pkg::DCNT_W'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req.start) begin
         quo_ff <= req.dividend;
         rem_ff <= '0;
         dsr_ff <= req.divisor;
      end else if (busy_ff) begin
         quo_ff <= {quo_ff[mgs_pkg::DVD_W-2:0], ge};
         rem_ff <= ge ? diff[mgs_pkg::DSR_W-1:0] : shift[mgs_pkg::DSR_W-1:0];
      end
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

[rtl/meter_grid_snap.sv]
// ----------------------------------------------------------------------------
// meter_grid_snap: meter-change table with grid snapping of tick positions
// Flow: a clear, an append or a query on an empty table goes straight to
//   the result; any other query scans the table up to the first entry above
//   the tick, then divides; a subdivision snap skips its last two divisions
//   when the beat start is already past the segment end.
// Throughput: one item at a time, the next one taken the cycle after the
//   result is loaded; the table scan (one entry per cycle) and the serial
//   divider (two divisions per measure snap, up to four per subdivision
//   snap) set it.
// Reset: synchronous, active high; empties the table, loads a quarter note
//   of 480 ticks and 4 subdivisions per beat, drops any result.
// ----------------------------------------------------------------------------
module meter_grid_snap (
   input  logic        clock,
   input  logic        reset,
   // item channel
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [1:0]  req_mode,
   input  logic [31:0] req_query_tick,
   input  logic [28:0] req_point_tick,
   input  logic [5:0]  req_point_numerator,
   input  logic [5:0]  req_point_denominator,
   input  logic        req_point_has_meter,
   // result channel
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [30:0] rsp_snapped_tick,
   output logic [1:0]  rsp_status,
   // register write port
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [0:0]  csr_index,
   input  logic [15:0] csr_data
);

   // ---------------------------------------------------------------------
   // State and registers
   // ---------------------------------------------------------------------
   mgs_pkg::state_type state_ff, state_in;

   logic [mgs_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [mgs_pkg::TICK_W-1:0] last_tick_ff;
   logic [15:0]                tpq_ff;
   logic [6:0]                 subd_ff;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [30:0]                rsp_tick_ff;
   logic [1:0]                 rsp_status_ff;

   // scan pointers: rd_idx is the entry being read, cmp_idx the one on rd_data
   logic [mgs_pkg::CNT_W-1:0]  rd_idx_ff;
   logic [mgs_pkg::CNT_W-1:0]  cmp_idx_ff;
   logic                       vld_ff, vld_in;

   // captured item and working values
   mgs_pkg::mode_type          mode_ff;
   logic signed [31:0]         q_ff;
   logic [mgs_pkg::TICK_W-1:0] pt_ff;
   logic [mgs_pkg::METER_W-1:0] num_ff;
   logic [mgs_pkg::METER_W-1:0] den_ff;
   logic [mgs_pkg::TICK_W-1:0] seg_ff;
   logic [17:0]                beat_ff;
   logic [23:0]                len_ff;
   logic [31:0]                rel_ff;
   logic [mgs_pkg::DVD_W-1:0]  n_ff;
   logic [32:0]                base_ff;
   logic [33:0]                start_ff;
   logic [25:0]                numb_ff;
   logic [6:0]                 idx_ff;
   logic [24:0]                prodc_ff;
   logic [30:0]                res_ff;
   logic [1:0]                 sts_ff;

   // ---------------------------------------------------------------------
   // Handshakes
   // ---------------------------------------------------------------------
   logic req_fire;
   logic rsp_load;

   assign req_fire  = req_valid && req_ready;
   assign csr_ready = 1'b1;
   assign rsp_load  = (state_ff == mgs_pkg::ST_DONE) && (!rsp_valid_ff || rsp_ready);

   // ---------------------------------------------------------------------
   // Table RAM: {tick, numerator, denominator}
   // ---------------------------------------------------------------------
   logic                        ram_we;
   logic [mgs_pkg::ENTRY_W-1:0] ram_rdata;
   logic [mgs_pkg::TICK_W-1:0]  rd_tick;
   logic [mgs_pkg::METER_W-1:0] rd_num;
   logic [mgs_pkg::METER_W-1:0] rd_den;

   mgs_ram #(
      .WIDTH (mgs_pkg::ENTRY_W),
      .DEPTH (mgs_pkg::TABLE_DEPTH)
   ) u_table (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (count_ff[mgs_pkg::ADDR_W-1:0]),
      .wr_data ({req_point_tick, req_point_numerator, req_point_denominator}),
      .rd_addr (rd_idx_ff[mgs_pkg::ADDR_W-1:0]),
      .rd_data (ram_rdata)
   );

   assign rd_tick = ram_rdata[mgs_pkg::ENTRY_W-1 -: mgs_pkg::TICK_W];
   assign rd_num  = ram_rdata[2*mgs_pkg::METER_W-1 -: mgs_pkg::METER_W];
   assign rd_den  = ram_rdata[mgs_pkg::METER_W-1:0];

   // ---------------------------------------------------------------------
   // Append and immediate results
   // ---------------------------------------------------------------------
   logic        app_full;
   logic        app_order;
   logic        is_query;
   logic [30:0] idle_res;
   logic [1:0]  idle_sts;

   assign app_full  = count_ff == mgs_pkg::CNT_W'(mgs_pkg::TABLE_DEPTH);
   assign app_order = (count_ff != '0) && (req_point_tick <= last_tick_ff);
   assign is_query  = (req_mode == mgs_pkg::MODE_SUBDIV) || (req_mode == mgs_pkg::MODE_BAR);
   assign ram_we    = req_fire && (req_mode == mgs_pkg::MODE_APPEND) && req_point_has_meter
                      && !app_full && !app_order;

   always_comb begin
      idle_res = '0;
      idle_sts = mgs_pkg::STS_OK;
      if (is_query) begin
         // empty table: clamp the tick to zero or above
         idle_res = req_query_tick[31] ? 31'd0 : req_query_tick[30:0];
      end else if ((req_mode == mgs_pkg::MODE_APPEND) && req_point_has_meter) begin
         // a full table wins over an out-of-order tick
         if (app_full) begin
            idle_sts = mgs_pkg::STS_FULL;
         end else if (app_order) begin
            idle_sts = mgs_pkg::STS_ORDER;
         end
      end
   end

   always_comb begin
      count_in = count_ff;
      if (req_fire && (req_mode == mgs_pkg::MODE_CLEAR)) begin
         count_in = '0;
      end else if (ram_we) begin
         count_in = count_ff + mgs_pkg::CNT_W'(1);
      end
   end

   // ---------------------------------------------------------------------
   // Scan: entry 0 always governs first; every later entry at or below the
   // tick takes over; the first entry above it ends the segment.
   // ---------------------------------------------------------------------
   logic scan_hit;
   logic scan_last;
   logic scan_done;

   assign scan_hit  = (cmp_idx_ff == '0) || ($signed({3'b000, rd_tick}) <= q_ff);
   assign scan_last = cmp_idx_ff == (count_ff - mgs_pkg::CNT_W'(1));
   assign scan_done = vld_ff && (!scan_hit || scan_last);
   assign vld_in    = (state_ff == mgs_pkg::ST_SCAN) && (rd_idx_ff < count_ff);

   // ---------------------------------------------------------------------
   // Arithmetic helpers
   // ---------------------------------------------------------------------
   logic [15:0]              tpq_eff;
   logic [6:0]               subd_eff;
   logic [5:0]               den_eff;
   logic                     can_clamp;
   logic                     early;
   logic signed [32:0]       rel_full;
   logic signed [35:0]       in_beat_full;
   logic [17:0]              in_beat;
   logic [23:0]              bar_raw;
   logic                     div_done;
   logic [mgs_pkg::DVD_W-1:0] div_quo;
   mgs_pkg::div_req_type     div_req;

   assign tpq_eff      = (tpq_ff == '0) ? 16'd1 : tpq_ff;
   assign subd_eff     = (subd_ff == '0) ? 7'd1 : subd_ff;
   assign den_eff      = (den_ff == '0) ? 6'd1 : den_ff;
   assign can_clamp    = seg_ff > pt_ff;
   assign early        = can_clamp && (start_ff >= 34'(seg_ff));
   assign rel_full     = $signed({q_ff[31], q_ff}) - $signed({4'b0000, pt_ff});
   assign in_beat_full = $signed({{4{q_ff[31]}}, q_ff}) - $signed({2'b00, start_ff});
   assign in_beat      = in_beat_full[35] ? 18'd0 : in_beat_full[17:0];
   assign bar_raw      = 24'(num_ff) * 24'(beat_ff);

   mgs_div u_div (
      .clock    (clock),
      .reset    (reset),
      .req      (div_req),
      .done     (div_done),
      .quotient (div_quo)
   );

   // ---------------------------------------------------------------------
   // Sequencer: next state
   // ---------------------------------------------------------------------
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         mgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               state_in = (is_query && (count_ff != '0)) ? mgs_pkg::ST_SCAN
                                                         : mgs_pkg::ST_DONE;
            end
         end
         mgs_pkg::ST_SCAN:     if (scan_done) state_in = mgs_pkg::ST_ISS_BEAT;
         mgs_pkg::ST_ISS_BEAT: state_in = mgs_pkg::ST_DIV_BEAT;
         mgs_pkg::ST_DIV_BEAT: if (div_done) state_in = mgs_pkg::ST_LEN;
         mgs_pkg::ST_LEN:      state_in = mgs_pkg::ST_ISS_A;
         mgs_pkg::ST_ISS_A:    state_in = mgs_pkg::ST_DIV_A;
         mgs_pkg::ST_DIV_A:    if (div_done) state_in = mgs_pkg::ST_MUL_A;
         mgs_pkg::ST_MUL_A:    state_in = mgs_pkg::ST_SUM_A;
         mgs_pkg::ST_SUM_A:    state_in = mgs_pkg::ST_CHK;
         mgs_pkg::ST_CHK: begin
            state_in = ((mode_ff == mgs_pkg::MODE_BAR) || early) ? mgs_pkg::ST_DONE
                                                                 : mgs_pkg::ST_ISS_B;
         end
         mgs_pkg::ST_ISS_B:    state_in = mgs_pkg::ST_DIV_B;
         mgs_pkg::ST_DIV_B:    if (div_done) state_in = mgs_pkg::ST_MUL_B;
         mgs_pkg::ST_MUL_B:    state_in = mgs_pkg::ST_ISS_C;
         mgs_pkg::ST_ISS_C:    state_in = mgs_pkg::ST_DIV_C;
         mgs_pkg::ST_DIV_C:    if (div_done) state_in = mgs_pkg::ST_DONE;
         mgs_pkg::ST_DONE:     if (rsp_load) state_in = mgs_pkg::ST_IDLE;
         default:              state_in = mgs_pkg::ST_IDLE;
      endcase
   end

   // ---------------------------------------------------------------------
   // Sequencer: outputs (ready and divider launches)
   // ---------------------------------------------------------------------
   always_comb begin
      req_ready = 1'b0;
      div_req   = '0;
      unique case (state_ff)
         mgs_pkg::ST_IDLE: req_ready = 1'b1;
         mgs_pkg::ST_ISS_BEAT: begin
            // beat = 4 * quarter-note ticks / denominator
            div_req.start    = 1'b1;
            div_req.dividend = mgs_pkg::DVD_W'({tpq_eff, 2'b00});
            div_req.divisor  = mgs_pkg::DSR_W'(den_eff);
         end
         mgs_pkg::ST_ISS_A: begin
            // whole beats, or measures rounded to nearest
            div_req.start    = 1'b1;
            div_req.dividend = (mode_ff == mgs_pkg::MODE_BAR)
                               ? mgs_pkg::DVD_W'(rel_ff) + mgs_pkg::DVD_W'(len_ff >> 1)
                               : mgs_pkg::DVD_W'(rel_ff);
            div_req.divisor  = len_ff;
         end
         mgs_pkg::ST_ISS_B: begin
            // nearest subdivision inside the beat
            div_req.start    = 1'b1;
            div_req.dividend = mgs_pkg::DVD_W'(numb_ff);
            div_req.divisor  = mgs_pkg::DSR_W'(beat_ff);
         end
         mgs_pkg::ST_ISS_C: begin
            // subdivision offset in ticks
            div_req.start    = 1'b1;
            div_req.dividend = mgs_pkg::DVD_W'(prodc_ff);
            div_req.divisor  = mgs_pkg::DSR_W'(subd_eff);
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // Control registers
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= mgs_pkg::ST_IDLE;
         count_ff     <= '0;
         tpq_ff       <= 16'd480;
         subd_ff      <= 7'd4;
         rsp_valid_ff <= 1'b0;
         vld_ff       <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         vld_ff       <= vld_in;
         if (csr_valid && csr_ready) begin
            case (csr_index[0])
               mgs_pkg::CSR_TPQ:  tpq_ff  <= csr_data;
               mgs_pkg::CSR_SUBD: subd_ff <= csr_data[6:0];
               default:           tpq_ff  <= tpq_ff;
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------
   // Datapath registers: advance one step per sequencer state
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (ram_we) begin
         last_tick_ff <= req_point_tick;
      end
      if (rsp_load) begin
         rsp_tick_ff   <= res_ff;
         rsp_status_ff <= sts_ff;
      end
      case (state_ff)
         mgs_pkg::ST_IDLE: begin
            if (req_fire) begin
               mode_ff   <= req_mode;
               q_ff      <= $signed(req_query_tick);
               rd_idx_ff <= '0;
               seg_ff    <= mgs_pkg::SEG_END_DEFAULT;
               res_ff    <= idle_res;
               sts_ff    <= idle_sts;
            end
         end
         mgs_pkg::ST_SCAN: begin
            rd_idx_ff  <= rd_idx_ff + mgs_pkg::CNT_W'(1);
            cmp_idx_ff <= rd_idx_ff;
            if (vld_ff) begin
               if (scan_hit) begin
                  pt_ff  <= rd_tick;
                  num_ff <= rd_num;
                  den_ff <= rd_den;
               end else begin
                  seg_ff <= rd_tick;
               end
            end
         end
         mgs_pkg::ST_DIV_BEAT: begin
            if (div_done) begin
               beat_ff <= (div_quo == '0) ? 18'd1 : div_quo[17:0];
            end
         end
         mgs_pkg::ST_LEN: begin
            if (mode_ff == mgs_pkg::MODE_BAR) begin
               len_ff <= (bar_raw == '0) ? 24'd1 : bar_raw;
            end else begin
               len_ff <= 24'(beat_ff);
            end
            rel_ff <= rel_full[32] ? 32'd0 : rel_full[31:0];
         end
         mgs_pkg::ST_DIV_A: begin
            if (div_done) begin
               n_ff <= div_quo;
            end
         end
         mgs_pkg::ST_MUL_A: begin
            // quotient times length never exceeds the dividend, so 32 bits hold it
            base_ff <= 33'(n_ff[31:0] * 32'(len_ff));
         end
         mgs_pkg::ST_SUM_A: begin
            start_ff <= 34'(pt_ff) + 34'(base_ff);
         end
         mgs_pkg::ST_CHK: begin
            // measure result, or a beat start already past the segment end
            res_ff  <= mgs_pkg::snap_limit(35'(start_ff), seg_ff, can_clamp);
            numb_ff <= 26'(in_beat) * 26'(subd_eff) + 26'(beat_ff >> 1);
         end
         mgs_pkg::ST_DIV_B: begin
            if (div_done) begin
               idx_ff <= (div_quo > mgs_pkg::DVD_W'(subd_eff)) ? subd_eff : div_quo[6:0];
            end
         end
         mgs_pkg::ST_MUL_B: begin
            prodc_ff <= 25'(idx_ff) * 25'(beat_ff);
         end
         mgs_pkg::ST_DIV_C: begin
            if (div_done) begin
               res_ff <= mgs_pkg::snap_limit(35'(start_ff) + 35'(div_quo), seg_ff, can_clamp);
            end
         end
         default: begin
            res_ff <= res_ff;
         end
      endcase
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_snapped_tick = rsp_tick_ff;
   assign rsp_status       = rsp_status_ff;

endmodule

[rtl/mgs_check.sv]
// ----------------------------------------------------------------------------
// mgs_check: port-level checks on meter_grid_snap
// Watches the item and result channels over time; bound to every instance.
// ----------------------------------------------------------------------------
module mgs_check (
   input logic        clock,
   input logic        reset,
   input logic        req_valid,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [30:0] rsp_snapped_tick,
   input logic [1:0]  rsp_status
);

   // a waiting result holds its value
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_snapped_tick)
                                  && $stable(rsp_status))
      else $error("result changed while stalled");

   // no result survives reset
   a_rsp_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid after reset");

   // only three status codes exist
   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_status <= mgs_pkg::STS_ORDER)
      else $error("undefined status code");

   // a dropped point carries no tick
   a_drop_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != mgs_pkg::STS_OK) |-> rsp_snapped_tick == 31'd0)
      else $error("dropped point with non-zero tick");

   // one item at a time: ready drops once an item is accepted
   a_one_item: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("item accepted while busy");

endmodule

bind meter_grid_snap mgs_check u_mgs_check (
   .clock            (clock),
   .reset            (reset),
   .req_valid        (req_valid),
   .req_ready        (req_ready),
   .rsp_valid        (rsp_valid),
   .rsp_ready        (rsp_ready),
   .rsp_snapped_tick (rsp_snapped_tick),
   .rsp_status       (rsp_status)
);

[verif/meter_grid_snap_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// meter_grid_snap_tb: self-checking bench for the meter grid snap block
// Loads meter tables, issues snap queries in both grid modes, predicts every
// result with a behavioural model and checks it under random idling.
// ----------------------------------------------------------------------------
module meter_grid_snap_tb;

   // one outstanding expectation
   typedef struct {
      logic [30:0]         tick;
      mgs_pkg::status_type status;
   } snap_result_type;

   // scoreboard: carries its own copy of the table and registers
   class snap_scoreboard;
      longint     ptick [mgs_pkg::TABLE_DEPTH];
      longint     pnum [mgs_pkg::TABLE_DEPTH];
      longint     pden [mgs_pkg::TABLE_DEPTH];
      int         count;
      longint     tpq;
      longint     subd;
      snap_result_type pending[$];
      int         errors;
      int         checked;

      function void clear_all();
         count = 0;
         tpq   = 480;
         subd  = 4;
         errors = 0;
         checked = 0;
      endfunction

      function void write_reg(logic idx, logic [15:0] data);
         if (idx == mgs_pkg::CSR_TPQ) tpq = data;
         else subd = data[6:0];
      endfunction

      function longint sat(longint v);
         if (v < 0) return 0;
         if (v > 64'sd2147483647) return 64'sd2147483647;
         return v;
      endfunction

      function longint beat_of(int p);
         longint t, d, b;
         t = (tpq == 0) ? 1 : tpq;
         d = (pden[p] == 0) ? 1 : pden[p];
         b = t * 4 / d;
         return (b < 1) ? 1 : b;
      endfunction

      // snap the tick; to_bar picks measure grid
      function longint snap(longint q, bit to_bar);
         int     g;
         longint seg, pt, beat, bar, rel, st, w, idx, s, sd;
         bit     cc;
         g = 0;
         for (int i = 0; i < count; i++) begin
            if (ptick[i] > q) break;
            g = i;
         end
         seg  = (g + 1 < count) ? ptick[g+1] : 64'sd536870911;
         pt   = ptick[g];
         beat = beat_of(g);
         cc   = seg > pt;
         rel  = q - pt;
         if (rel < 0) rel = 0;
         if (to_bar) begin
            bar = pnum[g] * beat;
            if (bar < 1) bar = 1;
            s = pt + ((rel + bar / 2) / bar) * bar;
         end else begin
            sd = (subd == 0) ? 1 : subd;
            st = pt + (rel / beat) * beat;
            if (st >= seg && cc) return sat(seg);
            w = q - st;
            if (w < 0) w = 0;
            idx = (w * sd + beat / 2) / beat;
            if (idx > sd) idx = sd;
            s = st + (idx * beat) / sd;
         end
         if (s >= seg && cc) s = seg;
         return sat(s);
      endfunction

      function void note_item(mgs_pkg::mode_type m, logic [31:0] q, logic [28:0] pt,
                              logic [5:0] nu, logic [5:0] de, logic has);
         snap_result_type r;
         r.tick = '0;
         r.status = mgs_pkg::STS_OK;
         case (m)
            mgs_pkg::MODE_CLEAR: count = 0;
            mgs_pkg::MODE_APPEND: begin
               if (has) begin
                  if (count >= mgs_pkg::TABLE_DEPTH) r.status = mgs_pkg::STS_FULL;
                  else if (count > 0 && pt <= ptick[count-1]) r.status = mgs_pkg::STS_ORDER;
                  else begin
                     ptick[count] = pt;
                     pnum[count]  = nu;
                     pden[count]  = de;
                     count++;
                  end
               end
            end
            default: begin
               if (count == 0) r.tick = 31'(sat(longint'($signed(q))));
               else r.tick = 31'(snap(longint'($signed(q)), m == mgs_pkg::MODE_BAR));
            end
         endcase
         pending = {pending, r};
      endfunction

      function void check_result(logic [30:0] t, mgs_pkg::status_type s);
         snap_result_type e;
         checked++;
         if (pending.size() == 0) begin
            $error("result with nothing expected: tick %0d status %0d", t, s);
            errors++;
            return;
         end
         e = pending.pop_front();
         if (t !== e.tick) begin
            $error("snapped_tick: expected %0d, got %0d", e.tick, t);
            errors++;
         end
         if (s !== e.status) begin
            $error("status: expected %0d, got %0d", e.status, s);
            errors++;
         end
      endfunction
   endclass

   logic        clock = 0;
   logic        reset = 1;
   logic        req_valid = 0;
   logic        req_ready;
   logic [1:0]  req_mode = mgs_pkg::MODE_CLEAR;
   logic [31:0] req_query_tick = '0;
   logic [28:0] req_point_tick = '0;
   logic [5:0]  req_point_numerator = '0;
   logic [5:0]  req_point_denominator = '0;
   logic        req_point_has_meter = 0;
   logic        rsp_valid;
   logic        rsp_ready = 0;
   logic [30:0] rsp_snapped_tick;
   logic [1:0]  rsp_status;
   logic        csr_valid = 0;
   logic        csr_ready;
   logic [0:0]  csr_index = '0;
   logic [15:0] csr_data = '0;

   snap_scoreboard grid = new();
   longint cycles = 0;
   int     burst_left = 0;
   int     bars_seen = 0;
   int     subdiv_seen = 0;
   logic [28:0] last_tick;

   meter_grid_snap dut (.*);

   initial begin
      forever #10 clock = ~clock;
   end

   // receiver: stall in runs of its own, sometimes none at all
   int stall_mode = 0;
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset && rsp_valid && rsp_ready)
         grid.check_result(rsp_snapped_tick, rsp_status);
      if (cycles % 3000 == 0) stall_mode <= $urandom_range(0, 2);
      case (stall_mode)
         0: rsp_ready <= 1'b1;
         1: rsp_ready <= ($urandom_range(0, 3) != 0);
         default: rsp_ready <= ($urandom_range(0, 9) < 3);
      endcase
   end

   // abort a hung run
   always @(posedge clock) begin
      if (cycles > 2_000_000) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   // drive one item, idling between bursts, and hold it until taken;
   // valid stays high inside a burst and drops when the burst ends
   task automatic send_item(mgs_pkg::mode_type m, logic [31:0] q, logic [28:0] pt,
                            logic [5:0] nu, logic [5:0] de, logic has);
      if (burst_left == 0) begin
         repeat ($urandom_range(1, 40)) @(posedge clock);
         burst_left = $urandom_range(1, 12);
      end
      burst_left--;
      req_valid             <= 1'b1;
      req_mode              <= m;
      req_query_tick        <= q;
      req_point_tick        <= pt;
      req_point_numerator   <= nu;
      req_point_denominator <= de;
      req_point_has_meter   <= has;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      grid.note_item(m, q, pt, nu, de, has);
      if (m == mgs_pkg::MODE_BAR) bars_seen++;
      if (m == mgs_pkg::MODE_SUBDIV) subdiv_seen++;
      if (burst_left == 0) req_valid <= 1'b0;
   endtask

   // hold until every expected item has come back, then let the block settle
   task automatic drain();
      if (burst_left != 0) begin
         req_valid <= 1'b0;
         burst_left = 0;
      end
      while (grid.pending.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
   endtask

   task automatic write_csr(logic idx, logic [15:0] data);
      drain();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= data;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      grid.write_reg(idx, data);
      csr_valid <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_query(logic [31:0] q);
      send_item($urandom_range(0, 1) ? mgs_pkg::MODE_BAR : mgs_pkg::MODE_SUBDIV, q,
                29'($urandom()), 6'($urandom()), 6'($urandom()), 1'($urandom()));
   endtask

   // build an ascending table of n points with random meters
   task automatic load_table(int n, int step_max);
      logic [28:0] t;
      send_item(mgs_pkg::MODE_CLEAR, $urandom(), 29'($urandom()), 6'($urandom()),
                6'($urandom()), 1'b0);
      t = 29'($urandom_range(0, 2000));
      for (int i = 0; i < n; i++) begin
         send_item(mgs_pkg::MODE_APPEND, $urandom(), t, 6'($urandom_range(0, 63)),
                   6'($urandom_range(0, 63)), 1'b1);
         last_tick = t;
         t = t + 29'($urandom_range(1, step_max));
      end
   endtask

   // query near the table, sometimes anywhere
   function automatic logic [31:0] pick_tick();
      case ($urandom_range(0, 5))
         0: return $urandom();
         1: return 32'($signed(-$urandom_range(0, 5000)));
         2: return 32'(last_tick) + $urandom_range(0, 100000);
         default: return $urandom_range(0, 32'(last_tick) + 5000);
      endcase
   endfunction

   initial begin
      int n;
      grid.clear_all();
      last_tick = 0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: empty table, extremes, special cases
      send_item(mgs_pkg::MODE_SUBDIV, 32'h8000_0000, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 32'h7FFF_FFFF, '1, '1, '1, 1);
      send_item(mgs_pkg::MODE_APPEND, 0, 1000, 4, 4, 1'b0);      // no meter
      send_item(mgs_pkg::MODE_APPEND, 0, 1000, 4, 4, 1'b1);
      send_item(mgs_pkg::MODE_APPEND, 0, 1000, 3, 8, 1'b1);      // equal tick
      send_item(mgs_pkg::MODE_APPEND, 0, 500, 3, 8, 1'b1);       // lower tick
      send_item(mgs_pkg::MODE_APPEND, 0, 5000, 0, 0, 1'b1);      // zero meter
      send_item(mgs_pkg::MODE_APPEND, 0, 9000, 63, 63, 1'b1);    // beyond 32
      send_item(mgs_pkg::MODE_APPEND, 0, 29'h1FFF_FFFE, 1, 1, 1'b1);
      send_item(mgs_pkg::MODE_SUBDIV, 10, 0, 0, 0, 0);           // before first
      send_item(mgs_pkg::MODE_BAR, 32'hFFFF_FFFF, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_SUBDIV, 1250, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 4990, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 7000, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_SUBDIV, 8999, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 32'h7FFF_FFFF, 0, 0, 0, 0);   // last segment
      send_item(mgs_pkg::MODE_SUBDIV, 32'h7FFF_FFFF, 0, 0, 0, 0);
      write_csr(mgs_pkg::CSR_TPQ, 16'hFFFF);
      write_csr(mgs_pkg::CSR_SUBD, 16'd64);
      send_item(mgs_pkg::MODE_SUBDIV, 32'h2000_0000, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 12345, 0, 0, 0, 0);
      write_csr(mgs_pkg::CSR_TPQ, 16'd0);
      write_csr(mgs_pkg::CSR_SUBD, 16'hFF80);                   // zero subdivisions
      send_item(mgs_pkg::MODE_SUBDIV, 9001, 0, 0, 0, 0);
      send_item(mgs_pkg::MODE_BAR, 6000, 0, 0, 0, 0);

      // fill the table to overflow
      load_table(mgs_pkg::TABLE_DEPTH, 50);
      send_item(mgs_pkg::MODE_APPEND, 0, last_tick + 1, 4, 4, 1'b1);   // table full
      send_query(pick_tick());
      drain();                                                   // pause for all items

      // random phases under several register settings
      for (int ph = 0; ph < 8; ph++) begin
         case (ph)
            0: begin
               write_csr(mgs_pkg::CSR_TPQ, 16'd480);
               write_csr(mgs_pkg::CSR_SUBD, 16'd4);
            end
            1: begin
               write_csr(mgs_pkg::CSR_TPQ, 16'd1);
               write_csr(mgs_pkg::CSR_SUBD, 16'd1);
            end
            2: begin
               write_csr(mgs_pkg::CSR_TPQ, 16'hFFFF);
               write_csr(mgs_pkg::CSR_SUBD, 16'd64);
            end
            default: begin
               write_csr(mgs_pkg::CSR_TPQ, 16'($urandom_range(1, 65535)));
               write_csr(mgs_pkg::CSR_SUBD, 16'($urandom_range(1, 127)));
            end
         endcase
         for (int s = 0; s < 4; s++) begin
            n = ($urandom_range(0, 9) == 0) ? mgs_pkg::TABLE_DEPTH : $urandom_range(1, 8);
            load_table(n, ($urandom_range(0, 3) == 0) ? 29'h0FF_FFFF : 4000);
            repeat ($urandom_range(15, 22)) begin
               if ($urandom_range(0, 15) == 0)
                  send_item(mgs_pkg::MODE_APPEND, $urandom(), 29'($urandom()),
                            6'($urandom()), 6'($urandom()), 1'($urandom()));
               else
                  send_query(pick_tick());
            end
         end
      end

      drain();
      repeat (300) @(posedge clock);
      $display("Covered %0d subdivision and %0d measure queries, %0d items checked.",
               subdiv_seen, bars_seen, grid.checked);
      if (grid.errors == 0 && grid.pending.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end
endmodule

[meter_grid_snap.f]
rtl/mgs_pkg.sv
rtl/mgs_ram.sv
rtl/mgs_div.sv
rtl/meter_grid_snap.sv
rtl/mgs_check.sv
verif/meter_grid_snap_tb.sv
